FILE: hw/rtl/chm_pkg.sv
package chm_pkg;

   // Configuration defaults
   localparam int DEFAULT_BUCKETS     = 16;
   localparam int NUM_BUCKETS_DEFAULT = 16;
   localparam int NUM_ENTRIES_DEFAULT = 64;
   localparam int KEY_W               = 64;
   localparam int VALUE_W             = 64;
   localparam int TOTAL_W             = 7;
   localparam int CSR_W               = 5;

   // Opcodes
   localparam logic [1:0] OP_PUT    = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_ZERO_KEY  = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] value_out;
      logic [TOTAL_W-1:0] entry_total;
   } rsp_type;

endpackage

FILE: hw/rtl/chm_ram.sv
module chm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: hw/rtl/chm_mod.sv
module chm_mod
   import chm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   input  logic [4:0]       divisor,
   output logic             done,
   output logic [4:0]       remainder
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [4:0]       div_ff, div_in;
   logic [4:0]       rem_ff, rem_in;
   logic [5:0]       part;
   logic [4:0]       acc;

   // Four key bits folded into the remainder per cycle, most significant key bits first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      key_in  = key_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      acc     = rem_ff;
      part    = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         key_in  = key;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < 4; i++) begin
            part = {acc, key_ff[KEY_W-1-i]};
            if (part >= {1'b0, div_ff}) begin
               part = part - {1'b0, div_ff};
            end
            acc = part[4:0];
         end
         rem_in = acc;
         key_in = {key_ff[KEY_W-5:0], 4'd0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'hF) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      key_ff <= key_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/chained_hash_map_unit.sv
// Key-value map with separate chaining over a pool of NUM_ENTRIES entries and up
// to NUM_BUCKETS chains. The bucket is key modulo the active bucket count
// (csr 0 means 16; values above NUM_BUCKETS use NUM_BUCKETS). One request is
// worked at a time: the remainder unit folds 4 key bits per cycle into the
// remainder and registers the result, and each chain step waits on the registered
// entry memory read. A response held by rsp_stall keeps the current request in
// S_DONE, which blocks the next request. After reset the block clears the bucket
// heads, one per cycle, and holds req_stall high meanwhile. A put of a new key
// takes any free pool entry and links it at the chain head; a full pool reports
// status 2.
module chained_hash_map_unit
   import chm_pkg::*;
#(
   parameter int NUM_BUCKETS = NUM_BUCKETS_DEFAULT,
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int BIW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int EIW = $clog2(NUM_ENTRIES);
   localparam int LW  = $clog2(NUM_ENTRIES + 1);
   localparam int EW  = KEY_W + VALUE_W + LW;
   localparam logic [LW-1:0] NULL_LINK = LW'(NUM_ENTRIES);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_MOD, S_HEAD, S_LOAD, S_WALK, S_CHK, S_HIT, S_MISS, S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CSR_W-1:0]    bc_ff;
   logic [BIW-1:0]      clr_ff, clr_in;
   logic [1:0]          op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [BIW-1:0]      bidx_ff, bidx_in;
   logic [LW-1:0]       head_ff, head_in;
   logic [LW-1:0]       cur_ff, cur_in;
   logic [LW-1:0]       prev_ff, prev_in;
   logic [KEY_W-1:0]    pkey_ff, pkey_in;
   logic [VALUE_W-1:0]  pval_ff, pval_in;
   logic [LW-1:0]       hit_ff, hit_in;
   logic [VALUE_W-1:0]  hval_ff, hval_in;
   logic [LW-1:0]       hlink_ff, hlink_in;
   logic [LW-1:0]       count_ff, count_in;
   logic [LW-1:0]       fsp_ff, fsp_in;
   logic [LW-1:0]       fresh_ff, fresh_in;
   logic [1:0]          stat_ff, stat_in;
   logic [VALUE_W-1:0]  vout_ff, vout_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [4:0]          div_sel;
   logic                mod_start, mod_done;
   logic [4:0]          mod_rem;
   logic [BIW+4:0]      rem_ext;
   logic [LW+6:0]       cnt_ext;

   logic                bk_we;
   logic [BIW-1:0]      bk_waddr;
   logic [LW-1:0]       bk_wdata, bk_rdata;
   logic                en_we;
   logic [EIW-1:0]      en_waddr;
   logic [EW-1:0]       en_wdata, en_rdata;
   logic [KEY_W-1:0]    rd_key;
   logic [VALUE_W-1:0]  rd_val;
   logic [LW-1:0]       rd_link;
   logic                fs_we;
   logic [EIW-1:0]      fs_waddr, fs_wdata, fs_rdata, fs_raddr;
   logic [LW-1:0]       slot;

   // Active divisor
   always_comb begin
      div_sel = (bc_ff == '0) ? 5'(DEFAULT_BUCKETS) : bc_ff;
      if (int'(div_sel) > NUM_BUCKETS) begin
         div_sel = 5'(NUM_BUCKETS);
      end
   end

   assign rem_ext = {{BIW{1'b0}}, mod_rem};
   assign {rd_key, rd_val, rd_link} = en_rdata;
   assign fs_raddr = EIW'(fsp_ff - LW'(1));
   assign slot     = (fsp_ff != '0) ? {{(LW-EIW){1'b0}}, fs_rdata} : fresh_ff;
   assign cnt_ext  = {7'd0, count_ff};

   chm_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .key       (req_data.key),
      .divisor   (div_sel),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   chm_ram #(.Width(LW), .Depth(NUM_BUCKETS)) u_bucket (
      .clock   (clock),
      .wr_en   (bk_we),
      .wr_addr (bk_waddr),
      .wr_data (bk_wdata),
      .rd_addr (bidx_ff),
      .rd_data (bk_rdata)
   );

   chm_ram #(.Width(EW), .Depth(NUM_ENTRIES)) u_entry (
      .clock   (clock),
      .wr_en   (en_we),
      .wr_addr (en_waddr),
      .wr_data (en_wdata),
      .rd_addr (cur_ff[EIW-1:0]),
      .rd_data (en_rdata)
   );

   chm_ram #(.Width(EIW), .Depth(NUM_ENTRIES)) u_free (
      .clock   (clock),
      .wr_en   (fs_we),
      .wr_addr (fs_waddr),
      .wr_data (fs_wdata),
      .rd_addr (fs_raddr),
      .rd_data (fs_rdata)
   );

   // Sequence one request: remainder, head read, chain walk, update
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      bidx_in      = bidx_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      pkey_in      = pkey_ff;
      pval_in      = pval_ff;
      hit_in       = hit_ff;
      hval_in      = hval_ff;
      hlink_in     = hlink_ff;
      count_in     = count_ff;
      fsp_in       = fsp_ff;
      fresh_in     = fresh_ff;
      stat_in      = stat_ff;
      vout_in      = vout_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      mod_start    = 1'b0;
      bk_we        = 1'b0;
      bk_waddr     = bidx_ff;
      bk_wdata     = NULL_LINK;
      en_we        = 1'b0;
      en_waddr     = slot[EIW-1:0];
      en_wdata     = {key_ff, val_ff, head_ff};
      fs_we        = 1'b0;
      fs_waddr     = fsp_ff[EIW-1:0];
      fs_wdata     = hit_ff[EIW-1:0];
      req_stall    = 1'b1;

      case (state_ff)
         S_INIT: begin
            bk_we    = 1'b1;
            bk_waddr = clr_ff;
            clr_in   = clr_ff + BIW'(1);
            if (clr_ff == BIW'(NUM_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in   = req_data.opcode;
               key_in  = req_data.key;
               val_in  = req_data.value;
               vout_in = '0;
               stat_in = ST_OK;
               if (req_data.opcode == OP_UNUSED) begin
                  stat_in  = ST_NOT_FOUND;
                  state_in = S_DONE;
               end else if (req_data.key == '0) begin
                  stat_in  = ST_ZERO_KEY;
                  state_in = S_DONE;
               end else begin
                  // Launch the remainder on the accepted key
                  mod_start = 1'b1;
                  state_in  = S_MOD;
               end
            end
         end
         S_MOD: begin
            cur_in = NULL_LINK;
            if (mod_done) begin
               bidx_in  = rem_ext[BIW-1:0];
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            head_in  = bk_rdata;
            cur_in   = bk_rdata;
            prev_in  = NULL_LINK;
            state_in = S_WALK;
         end
         S_WALK: begin
            state_in = (cur_ff == NULL_LINK) ? S_MISS : S_CHK;
         end
         S_CHK: begin
            if (rd_key == key_ff) begin
               hit_in   = cur_ff;
               hval_in  = rd_val;
               hlink_in = rd_link;
               state_in = S_HIT;
            end else begin
               prev_in  = cur_ff;
               pkey_in  = rd_key;
               pval_in  = rd_val;
               cur_in   = rd_link;
               state_in = S_WALK;
            end
         end
         S_HIT: begin
            state_in = S_DONE;
            case (op_ff)
               OP_PUT: begin
                  en_we    = 1'b1;
                  en_waddr = hit_ff[EIW-1:0];
                  en_wdata = {key_ff, val_ff, hlink_ff};
               end
               OP_GET: begin
                  vout_in = hval_ff;
               end
               default: begin
                  if (prev_ff == NULL_LINK) begin
                     bk_we    = 1'b1;
                     bk_wdata = hlink_ff;
                  end else begin
                     en_we    = 1'b1;
                     en_waddr = prev_ff[EIW-1:0];
                     en_wdata = {pkey_ff, pval_ff, hlink_ff};
                  end
                  fs_we    = 1'b1;
                  fsp_in   = fsp_ff + LW'(1);
                  count_in = count_ff - LW'(1);
               end
            endcase
         end
         S_MISS: begin
            state_in = S_DONE;
            if (op_ff != OP_PUT) begin
               stat_in = ST_NOT_FOUND;
            end else if (count_ff == NULL_LINK) begin
               stat_in = ST_FULL;
            end else begin
               en_we    = 1'b1;
               bk_we    = 1'b1;
               bk_wdata = slot;
               count_in = count_ff + LW'(1);
               if (fsp_ff != '0) begin
                  fsp_in = fsp_ff - LW'(1);
               end else begin
                  fresh_in = fresh_ff + LW'(1);
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status      = stat_ff;
               rsp_in.value_out   = vout_ff;
               rsp_in.entry_total = cnt_ext[6:0];
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_ff       <= '0;
         bc_ff        <= CSR_W'(DEFAULT_BUCKETS);
         count_ff     <= '0;
         fsp_ff       <= '0;
         fresh_ff     <= '0;
         cur_ff       <= NULL_LINK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         fsp_ff       <= fsp_in;
         fresh_ff     <= fresh_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bc_ff <= csr_wr_data;
         end
      end
      op_ff    <= op_in;
      key_ff   <= key_in;
      val_ff   <= val_in;
      bidx_ff  <= bidx_in;
      head_ff  <= head_in;
      prev_ff  <= prev_in;
      pkey_ff  <= pkey_in;
      pval_ff  <= pval_in;
      hit_ff   <= hit_in;
      hval_ff  <= hval_in;
      hlink_ff <= hlink_in;
      stat_ff  <= stat_in;
      vout_ff  <= vout_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
